/* src/rational_arithmetic_unit_defines.svh */
// Assertion macros for the fraction unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked on every edge out of reset
`define RAU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RAU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rau_pkg.sv */
// Shared types and codes of the fraction unit
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
	localparam logic [2:0] ACT_SIMPLIFY = 3'd0;
	localparam logic [2:0] ACT_ADD      = 3'd1;
	localparam logic [2:0] ACT_SUB      = 3'd2;
	localparam logic [2:0] ACT_MUL      = 3'd3;
	localparam logic [2:0] ACT_DIV      = 3'd4;

	localparam int RES_NUM_W = 32;
	localparam int RES_DEN_W = 31;

	// Datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,      // latch operands
		CMD_GCD_SA,    // gcd(|a_num|, a_den)
		CMD_GCD_DD,    // gcd(a_den, b_den)
		CMD_GCD_STEP,  // one subtract-shift step of remainder
		CMD_DIV_START, // start x / g
		CMD_DIV_STEP,
		CMD_MUL1,      // first products
		CMD_MUL2,      // second products / final
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic gcd_done;  // remainder chain finished (y == 0)
		logic div_done;
	} dp_status_t;
endpackage
`default_nettype wire

/* src/rau_datapath.sv */
// Datapath: operand registers, shared shift-subtract divider, multiplier, result
`timescale 1ns / 1ps
`default_nettype none
module rau_datapath #(
	parameter int OPERAND_BITS = 16
) (
	input  wire logic                              clk,
	input  wire rau_pkg::cmd_t                     cmd,
	input  wire logic [2:0]                        action,
	input  wire logic signed [OPERAND_BITS-1:0]    a_num,
	input  wire logic [OPERAND_BITS-2:0]           a_den,
	input  wire logic signed [OPERAND_BITS-1:0]    b_num,
	input  wire logic [OPERAND_BITS-2:0]           b_den,
	output rau_pkg::dp_status_t                    status,
	output logic signed [rau_pkg::RES_NUM_W-1:0]   res_num,
	output logic signed [rau_pkg::RES_DEN_W-1:0]   res_den
);
	import rau_pkg::*;

	localparam int W   = OPERAND_BITS;       // magnitude width
	localparam int CW  = $clog2(W + 1);
	localparam int PW  = 2 * W;

	logic [2:0]          act_q;
	logic signed [W-1:0] an_q, bn_q;
	logic [W-2:0]        ad_q, bd_q;
	logic                neg_q;
	// remainder/division unit
	logic [W-1:0]        x_q, y_q, rem_q, quo_q, dvd_q;
	logic [CW-1:0]       cnt_q;
	logic                sel_q;          // second division pass
	logic [W-1:0]        g_q, q1_q, q2_q;
	logic signed [PW-1:0] p1_q, p2_q;
	logic signed [RES_NUM_W-1:0] rn_q;
	logic signed [RES_DEN_W-1:0] rd_q;

	logic [W-1:0] mag;
	logic [W:0]   trial;
	logic [W-1:0] rem_sh;
	logic         last;

	assign mag    = an_q[W-1] ? (~an_q + 1'b1) : an_q;
	assign rem_sh = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, y_q};
	assign last   = (cnt_q == CW'(1));

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				act_q <= action;
				an_q  <= a_num;
				bn_q  <= b_num;
				ad_q  <= a_den;
				bd_q  <= b_den;
			end
			CMD_GCD_SA: begin
				neg_q <= an_q[W-1];
				x_q   <= mag;
				y_q   <= {1'b0, ad_q};
				dvd_q <= mag;
				rem_q <= '0;
				cnt_q <= CW'(W);
			end
			CMD_GCD_DD: begin
				x_q   <= {1'b0, ad_q};
				y_q   <= {1'b0, bd_q};
				dvd_q <= {1'b0, ad_q};
				rem_q <= '0;
				cnt_q <= CW'(W);
			end
			CMD_GCD_STEP: begin
				// restoring division of x by y, one bit a cycle
				dvd_q <= {dvd_q[W-2:0], 1'b0};
				rem_q <= trial[W] ? rem_sh : trial[W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (last) begin
					x_q   <= y_q;
					y_q   <= trial[W] ? rem_sh : trial[W-1:0];
					dvd_q <= y_q;
					rem_q <= '0;
					cnt_q <= CW'(W);
				end
			end
			CMD_DIV_START: begin
				// x holds the gcd; divide the two dividends by it
				g_q   <= x_q;
				y_q   <= x_q;
				sel_q <= 1'b0;
				dvd_q <= (act_q == ACT_SIMPLIFY) ? mag : {1'b0, bd_q};
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= CW'(W);
			end
			CMD_DIV_STEP: begin
				dvd_q <= {dvd_q[W-2:0], 1'b0};
				rem_q <= trial[W] ? rem_sh : trial[W-1:0];
				quo_q <= {quo_q[W-2:0], ~trial[W]};
				cnt_q <= cnt_q - 1'b1;
				if (last) begin
					if (!sel_q) q1_q <= {quo_q[W-2:0], ~trial[W]};
					else        q2_q <= {quo_q[W-2:0], ~trial[W]};
					sel_q <= 1'b1;
					dvd_q <= {1'b0, ad_q};
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CW'(W);
				end
			end
			CMD_MUL1: begin
				case (act_q)
					ACT_ADD, ACT_SUB: begin
						p1_q <= PW'(an_q) * $signed({1'b0, q1_q});
						p2_q <= PW'(bn_q) * $signed({1'b0, q2_q});
					end
					ACT_MUL: begin
						p1_q <= PW'(an_q) * PW'(bn_q);
						p2_q <= $signed(PW'(ad_q)) * $signed(PW'(bd_q));
					end
					ACT_DIV: begin
						p1_q <= PW'(an_q) * $signed(PW'(bd_q));
						p2_q <= $signed(PW'(ad_q)) * PW'(bn_q);
					end
					default: begin
						p1_q <= '0;
						p2_q <= '0;
					end
				endcase
			end
			CMD_MUL2: begin
				// add/sub: denominator is q1 * a_den
				p2_q <= (act_q == ACT_SUB) ? (p1_q - p2_q) : (p1_q + p2_q);
				p1_q <= $signed(PW'(q1_q)) * $signed(PW'(ad_q));
			end
			CMD_FINISH: begin
				case (act_q)
					ACT_SIMPLIFY: begin
						if (mag == '0) begin
							rn_q <= '0;
							rd_q <= RES_DEN_W'(1);
						end else begin
							rn_q <= neg_q ? -$signed(RES_NUM_W'(q1_q))
							              : $signed(RES_NUM_W'(q1_q));
							rd_q <= $signed(RES_DEN_W'(q2_q));
						end
					end
					ACT_ADD, ACT_SUB: begin
						if (ad_q == '0 || bd_q == '0) begin
							rn_q <= '0;
							rd_q <= '0;
						end else begin
							rn_q <= RES_NUM_W'(p2_q);
							rd_q <= RES_DEN_W'(p1_q);
						end
					end
					ACT_MUL, ACT_DIV: begin
						rn_q <= RES_NUM_W'(p1_q);
						rd_q <= RES_DEN_W'(p2_q);
					end
					default: begin
						rn_q <= '0;
						rd_q <= '0;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign status.gcd_done = (y_q == '0);
	assign status.div_done = last && sel_q;
	assign res_num = rn_q;
	assign res_den = rd_q;
endmodule
`default_nettype wire

/* src/rau_ctrl.sv */
// Controller: sequences load, GCD, quotient and multiply steps
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [2:0]          action,
	input  wire rau_pkg::dp_status_t status,
	output rau_pkg::cmd_t            cmd,
	output logic                     busy,
	output logic                     done
);
	import rau_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_SETUP, ST_GCD, ST_DIVS, ST_DIV,
		ST_MUL1, ST_MUL2, ST_FIN, ST_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) begin
					act_q   <= action;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (act_q == ACT_SIMPLIFY || act_q == ACT_ADD || act_q == ACT_SUB)
						state_q <= ST_SETUP;
					else
						state_q <= ST_MUL1;
				end
				ST_SETUP: state_q <= ST_GCD;
				ST_GCD: if (status.gcd_done) begin
					state_q <= ST_DIVS;
				end
				ST_DIVS: state_q <= ST_DIV;
				ST_DIV: if (status.div_done) begin
					state_q <= (act_q == ACT_SIMPLIFY) ? ST_FIN : ST_MUL1;
				end
				ST_MUL1: state_q <= (act_q == ACT_ADD || act_q == ACT_SUB) ? ST_MUL2 : ST_FIN;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN: begin
					done    <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a zero divisor stops the chain at once; the result path covers it
	always_comb begin
		case (state_q)
			ST_IDLE:  cmd = start ? CMD_LOAD : CMD_NONE;
			ST_LOAD:  cmd = CMD_NONE;
			ST_SETUP: cmd = (act_q == ACT_SIMPLIFY) ? CMD_GCD_SA : CMD_GCD_DD;
			ST_GCD:   cmd = status.gcd_done ? CMD_NONE : CMD_GCD_STEP;
			ST_DIVS:  cmd = CMD_DIV_START;
			ST_DIV:   cmd = CMD_DIV_STEP;
			ST_MUL1:  cmd = CMD_MUL1;
			ST_MUL2:  cmd = CMD_MUL2;
			ST_FIN:   cmd = CMD_FINISH;
			default:  cmd = CMD_NONE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule
`default_nettype wire

/* src/rational_arithmetic_unit.sv */
// Top level of the fraction unit: controller plus datapath
//  channel  | signals                               | transfer
//  command  | start, action, a_num, a_den, b_num, b_den | start && !busy
//  result   | done, res_num, res_den                | done (one cycle)
// Multiply, divide and undefined actions go from LOAD through MUL1 to FIN, which raises done.
// Simplify, add and subtract run a bit-serial GCD (up to about 23 remainders at 16
// bits), then two quotient passes of OPERAND_BITS bits each.
// Busy drops the cycle after done. Reset clears the controller only.
// The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
	parameter int OPERAND_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [2:0]                      action,
	input  wire logic signed [OPERAND_BITS-1:0]  a_num,
	input  wire logic [OPERAND_BITS-2:0]         a_den,
	input  wire logic signed [OPERAND_BITS-1:0]  b_num,
	input  wire logic [OPERAND_BITS-2:0]         b_den,
	output logic                                 done,
	output logic signed [31:0]                   res_num,
	output logic signed [30:0]                   res_den
);
	import rau_pkg::*;

	cmd_t       cmd;
	dp_status_t status;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.status(status), .cmd(cmd), .busy(busy), .done(done)
	);

	rau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
		.clk(clk), .cmd(cmd), .action(action),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.status(status), .res_num(res_num), .res_den(res_den)
	);

	`RAU_ASSERT_IMP(a_done_busy, done, busy, "result strobe while idle")
	`RAU_ASSERT_NXT(a_start_busy, start && !busy, busy, "transfer did not raise busy")
	`RAU_ASSERT_NXT(a_done_once, done, !done, "result strobe held two cycles")
endmodule
`default_nettype wire

/* verif/rational_arithmetic_unit_tb.sv */
// Self-checking testbench for the fraction unit: predicted fractions against results
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int OB = 16;
	localparam int ITEMS = 600;
	localparam longint LIMIT = 1000000;

	typedef struct {
		logic [2:0] action;
		logic signed [OB-1:0] a_num;
		logic [OB-2:0] a_den;
		logic signed [OB-1:0] b_num;
		logic [OB-2:0] b_den;
	} frac_op_t;

	typedef struct {
		logic signed [31:0] num;
		logic signed [30:0] den;
	} frac_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] action = '0;
	logic signed [OB-1:0] a_num = '0;
	logic [OB-2:0] a_den = '0;
	logic signed [OB-1:0] b_num = '0;
	logic [OB-2:0] b_den = '0;
	logic busy, done;
	logic signed [31:0] res_num;
	logic signed [30:0] res_den;

	frac_op_t pending_ops[$];
	frac_res_t expected_fracs[$];
	int send_idle_pct = 12;
	int errors = 0;
	int sent = 0;
	int checked = 0;
	longint cycles = 0;

	rational_arithmetic_unit #(.OPERAND_BITS(OB)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.done(done), .res_num(res_num), .res_den(res_den)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint euclid_gcd(longint x, longint y);
		longint t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic frac_res_t compute_fraction(frac_op_t op);
		frac_res_t r;
		longint an, bn, ad, bd, g, mag, rn, rd, ma, mb;
		an = op.a_num;
		bn = op.b_num;
		ad = op.a_den;
		bd = op.b_den;
		rn = 0;
		rd = 0;
		case (op.action)
			ACT_SIMPLIFY: begin
				mag = (an < 0) ? -an : an;
				if (mag == 0) begin
					rd = 1;
				end else begin
					g = euclid_gcd(mag, ad);
					rn = (an < 0) ? -(mag / g) : mag / g;
					rd = ad / g;
				end
			end
			ACT_ADD, ACT_SUB: begin
				if (ad != 0 && bd != 0) begin
					g = euclid_gcd(ad, bd);
					ma = bd / g;
					mb = ad / g;
					rn = (op.action == ACT_ADD) ? an * ma + bn * mb : an * ma - bn * mb;
					rd = ma * ad;
				end
			end
			ACT_MUL: begin
				rn = an * bn;
				rd = ad * bd;
			end
			ACT_DIV: begin
				rn = an * bd;
				rd = ad * bn;
			end
			default: ;
		endcase
		r.num = rn[31:0];
		r.den = rd[30:0];
		return r;
	endfunction

	function automatic logic signed [OB-1:0] rand_num();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [OB-2:0] rand_den();
		case ($urandom_range(0, 7))
			0: return 15'h7fff;
			1: return 15'd1;
			2: return 15'($urandom_range(1, 60));
			3: return 15'($urandom_range(1, 12) * 210);
			default: return 15'($urandom_range(1, 32767));
		endcase
	endfunction

	function automatic frac_op_t make_op(logic [2:0] act, int an, int ad, int bn, int bd);
		frac_op_t op;
		op.action = act;
		op.a_num = 16'(an);
		op.a_den = 15'(ad);
		op.b_num = 16'(bn);
		op.b_den = 15'(bd);
		return op;
	endfunction

	// driver: hold start until the transfer, predict on acceptance
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (start && !busy) begin
				expected_fracs.push_back(compute_fraction(pending_ops.pop_front()));
				sent <= sent + 1;
			end
			if (!(start && busy)) begin
				if (pending_ops.size() > 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
					frac_op_t nx;
					nx = pending_ops[0];
					start <= 1'b1;
					action <= nx.action;
					a_num <= nx.a_num;
					a_den <= nx.a_den;
					b_num <= nx.b_num;
					b_den <= nx.b_den;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_fracs.size() == 0) begin
				$error("result with nothing expected: %0d/%0d", res_num, res_den);
				errors++;
			end else begin
				frac_res_t e;
				e = expected_fracs.pop_front();
				if (res_num !== e.num) begin
					$error("res_num expected %0d actual %0d", e.num, res_num);
					errors++;
				end
				if (res_den !== e.den) begin
					$error("res_den expected %0d actual %0d", e.den, res_den);
					errors++;
				end
				checked++;
			end
		end
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[rational_arithmetic_unit] ERROR");
			$finish;
		end
	end

	initial begin
		pending_ops.push_back(make_op(ACT_SIMPLIFY, 0, 7, 0, 1));
		pending_ops.push_back(make_op(ACT_SIMPLIFY, -12, 18, 0, 1));
		pending_ops.push_back(make_op(ACT_SIMPLIFY, 12, 18, 0, 1));
		pending_ops.push_back(make_op(ACT_SIMPLIFY, -5, 0, 0, 1));
		pending_ops.push_back(make_op(ACT_SIMPLIFY, 5, 0, 0, 1));
		pending_ops.push_back(make_op(ACT_SIMPLIFY, -32768, 32767, -1, 32767));
		pending_ops.push_back(make_op(ACT_SIMPLIFY, -32768, 16384, 0, 1));
		pending_ops.push_back(make_op(ACT_ADD, 1, 6, 1, 4));
		pending_ops.push_back(make_op(ACT_ADD, 32767, 32767, 32767, 32766));
		pending_ops.push_back(make_op(ACT_ADD, 3, 0, 1, 2));
		pending_ops.push_back(make_op(ACT_SUB, -32768, 32767, 32767, 32765));
		pending_ops.push_back(make_op(ACT_SUB, 1, 3, 2, 0));
		pending_ops.push_back(make_op(ACT_MUL, -32768, 32767, -32768, 32767));
		pending_ops.push_back(make_op(ACT_MUL, 32767, 1, -1, 1));
		pending_ops.push_back(make_op(ACT_DIV, 3, 4, 0, 5));
		pending_ops.push_back(make_op(ACT_DIV, -32768, 32767, -32768, 32767));
		pending_ops.push_back(make_op(ACT_DIV, 7, 9, -2, 3));
		pending_ops.push_back(make_op(3'd5, 1, 1, 1, 1));
		pending_ops.push_back(make_op(3'd6, -1, 2, 3, 4));
		pending_ops.push_back(make_op(3'd7, 32767, 32767, -32768, 32767));
		for (int i = 0; i < ITEMS; i++) begin
			frac_op_t op;
			op.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			op.a_num = rand_num();
			op.b_num = rand_num();
			op.a_den = ($urandom_range(0, 24) == 0) ? 15'd0 : rand_den();
			op.b_den = ($urandom_range(0, 24) == 0) ? 15'd0 : rand_den();
			pending_ops.push_back(op);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// sender idling phases by progress; the receiver cannot stall
		wait (sent >= (ITEMS + 20) / 3);
		send_idle_pct = 66;
		wait (sent >= 2 * (ITEMS + 20) / 3);
		send_idle_pct = 0;
		wait (pending_ops.size() == 0 && !start);
		wait (expected_fracs.size() == 0);
		repeat (400) @(posedge clk);
		$display("covered %0d fractions across simplify, add, subtract, multiply, divide", checked);
		$display("and undefined actions, including zero denominators and extreme operands");
		if (errors == 0) begin
			$display("[rational_arithmetic_unit] OK");
		end else begin
			$display("[rational_arithmetic_unit] ERROR");
		end
		$finish;
	end
endmodule

/* rational_arithmetic_unit.f */
+incdir+src
src/rau_pkg.sv
src/rau_datapath.sv
src/rau_ctrl.sv
src/rational_arithmetic_unit.sv
verif/rational_arithmetic_unit_tb.sv
